FILE: hw/rtl/tsw_pkg.sv
// ============================================================================
// tsw_pkg: shared types and constants of the tanh waveshaper
// Formats of the tanh argument, the table and the mix path, plus the
// configuration register map.
// ============================================================================
package tsw_pkg;

    // Default sizes
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int TANH_ENTRIES_DEF = 256;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DRIVE_W    = 15;
    localparam int GAIN_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRIVE  = 3'd0,
        CFG_MAKEUP = 3'd1,
        CFG_WET    = 3'd2,
        CFG_SHAPE  = 3'd3,
        CFG_ASYM   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        [DRIVE_W-1:0] drive_gain;          // Q2.13
        logic        [GAIN_W-1:0]  makeup_gain;         // Q1.15
        logic        [GAIN_W-1:0]  wet_mix;             // Q1.15
        logic signed [GAIN_W-1:0]  shape_amount;        // Q2.14
        logic        [GAIN_W-1:0]  negative_asymmetry;  // Q3.13
    } t_cfg;

    localparam logic [DRIVE_W-1:0] DRIVE_RST  = 15'd8192;
    localparam logic [GAIN_W-1:0]  MAKEUP_RST = 16'd32768;
    localparam logic [GAIN_W-1:0]  WET_RST    = 16'd32768;
    localparam logic [GAIN_W-1:0]  SHAPE_RST  = 16'd0;
    localparam logic [GAIN_W-1:0]  ASYM_RST   = 16'd8192;

    // Tanh argument: magnitude in Q.24
    localparam int ARG_FRAC        = 24;
    localparam int ARG_LIMIT_SHIFT = 27;    // |z| >= 8 saturates
    localparam int ASYM_FRAC       = 13;
    localparam int SHAPE_FRAC      = 14;
    localparam int Z1_W            = 27;    // after drive
    localparam int Z2_W            = 30;    // after asymmetry
    localparam int Z3_W            = 32;    // after shape
    localparam int KM_W            = 16;    // |1 + shape| in Q2.14

    // Tanh magnitude: Q1.30
    localparam int              TANH_W   = 31;
    localparam logic [TANH_W-1:0] TANH_ONE = 31'h4000_0000;

    // Mix path, Q.31 based
    localparam int X31_W  = 32;
    localparam int DIFF_W = 34;
    localparam int WET_FRAC = 15;
    localparam int MIX_W  = 36;
    localparam int PI_W   = DIFF_W + GAIN_W + 1;   // wet product
    localparam int PJ_W   = MIX_W + GAIN_W + 1;    // makeup product

endpackage

FILE: hw/rtl/tsw_if.sv
// ============================================================================
// tsw_if: sample stream channels
// Valid/ready channels carrying one audio sample per request.
// ============================================================================
interface tsw_in_if import tsw_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface tsw_out_if import tsw_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: hw/rtl/tsw_arg.sv
// ============================================================================
// tsw_arg: tanh argument pipeline
// Four stages: input register, drive gain, negative asymmetry, shape gain.
// Produces |z| in Q.24 and the sign of the tanh argument.
// ============================================================================
module tsw_arg import tsw_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_x,
    output logic        [Z3_W-1:0]        o_z,
    output logic                          o_sign
);

    localparam int SH   = SAMPLE_BITS - 12;          // drive product to Q.24
    localparam int PB_W = SAMPLE_BITS + DRIVE_W;
    localparam int PC_W = Z1_W + GAIN_W;
    localparam int PD_W = Z2_W + KM_W;

    logic en_a, en_b, en_c, en_d;

    logic                          r_a_v, r_b_v, r_c_v, r_d_v;
    logic signed [SAMPLE_BITS-1:0] r_a_x, r_b_x, r_c_x, r_d_x;
    logic        [Z1_W-1:0]        r_b_z;
    logic        [Z2_W-1:0]        r_c_z;
    logic        [Z3_W-1:0]        r_d_z;
    logic                          r_d_sign;

    logic        [SAMPLE_BITS-1:0] w_abs;
    logic        [PB_W-1:0]        w_prod_b, w_rnd_b;
    logic        [PC_W-1:0]        w_prod_c, w_rnd_c;
    logic        [PD_W-1:0]        w_prod_d, w_rnd_d;
    logic signed [KM_W:0]          w_k, w_kabs;
    logic        [KM_W-1:0]        w_km;
    logic        [Z1_W-1:0]        n_b_z;
    logic        [Z2_W-1:0]        n_c_z;
    logic        [Z3_W-1:0]        n_d_z;
    logic                          n_d_sign;

    // Stage enables: a stage loads when empty or when its successor moves
    assign en_d    = !r_d_v || i_ready;
    assign en_c    = !r_c_v || en_d;
    assign en_b    = !r_b_v || en_c;
    assign en_a    = !r_a_v || en_b;
    assign o_ready = en_a;

    // Drive: |x| * drive, rounded to Q.24
    assign w_abs    = r_a_x[SAMPLE_BITS-1] ? (~r_a_x + 1'b1) : r_a_x;
    assign w_prod_b = {{DRIVE_W{1'b0}}, w_abs} * {{SAMPLE_BITS{1'b0}}, i_cfg.drive_gain};
    assign w_rnd_b  = w_prod_b + (PB_W'(1) << (SH - 1));
    assign n_b_z    = w_rnd_b[SH +: Z1_W];

    // Asymmetry: only negative samples take the extra gain
    assign w_prod_c = {{GAIN_W{1'b0}}, r_b_z} * {{Z1_W{1'b0}}, i_cfg.negative_asymmetry};
    assign w_rnd_c  = w_prod_c + (PC_W'(1) << (ASYM_FRAC - 1));
    assign n_c_z    = r_b_x[SAMPLE_BITS-1] ? w_rnd_c[ASYM_FRAC +: Z2_W] : Z2_W'(r_b_z);

    // Shape: k = 1 + shape in Q2.14, magnitude and sign split
    assign w_k      = $signed({i_cfg.shape_amount[GAIN_W-1], i_cfg.shape_amount})
                      + $signed((KM_W+1)'(1 << SHAPE_FRAC));
    assign w_kabs   = w_k[KM_W] ? -w_k : w_k;
    assign w_km     = w_kabs[KM_W-1:0];
    assign w_prod_d = {{KM_W{1'b0}}, r_c_z} * {{Z2_W{1'b0}}, w_km};
    assign w_rnd_d  = w_prod_d + (PD_W'(1) << (SHAPE_FRAC - 1));
    assign n_d_z    = w_rnd_d[SHAPE_FRAC +: Z3_W];
    assign n_d_sign = r_c_x[SAMPLE_BITS-1] ^ w_k[KM_W];

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else begin
            if (en_a) r_a_v <= i_valid;
            if (en_b) r_b_v <= r_a_v;
            if (en_c) r_c_v <= r_b_v;
            if (en_d) r_d_v <= r_c_v;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_x <= i_sample;
        end
        if (en_b) begin
            r_b_x <= r_a_x;
            r_b_z <= n_b_z;
        end
        if (en_c) begin
            r_c_x <= r_b_x;
            r_c_z <= n_c_z;
        end
        if (en_d) begin
            r_d_x    <= r_c_x;
            r_d_z    <= n_d_z;
            r_d_sign <= n_d_sign;
        end
    end

    assign o_valid = r_d_v;
    assign o_x     = r_d_x;
    assign o_z     = r_d_z;
    assign o_sign  = r_d_sign;

    // A silent sample drives nothing into the shaper
    a_zero_arg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v && en_b && r_a_x == '0) |=> (r_b_z == '0))
        else $error("zero sample gave nonzero drive product");

endmodule

FILE: hw/rtl/tsw_tanh.sv
// ============================================================================
// tsw_tanh: table tanh with linear interpolation
// Three stages: table position, table read, interpolation. The table is
// built at elaboration; |z| >= 8 saturates to one.
// ============================================================================
module tsw_tanh import tsw_pkg::*; #(
    parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
    parameter int TANH_TABLE_ENTRIES = TANH_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic        [Z3_W-1:0]        i_z,
    input  logic                          i_sign,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_x,
    output logic        [TANH_W-1:0]      o_ym,
    output logic                          o_sign
);

    localparam int IW    = $clog2(TANH_TABLE_ENTRIES + 1);
    localparam int POS_W = ARG_LIMIT_SHIFT + IW;
    localparam int PG_W  = TANH_W + ARG_LIMIT_SHIFT;

    // Unsigned long division, shift and subtract, used only for the table build
    function automatic logic [63:0] div_u64(input logic [63:0] dvd,
                                            input logic [63:0] dvs);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], dvd[b]};
            if (rem >= {1'b0, dvs}) begin
                rem  = rem - {1'b0, dvs};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry i = tanh(8i/N) in Q1.30, as (1-E)/(1+E) with E = exp(-16i/N)
    function automatic logic [TANH_W-1:0] tanh_entry(input int unsigned idx);
        logic [63:0] r;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        r    = div_u64(64'(idx) << 30, 64'(TANH_TABLE_ENTRIES));
        sum  = 64'h8000_0000;
        term = 64'h8000_0000;
        for (int unsigned n = 1; n <= 14; n++) begin
            term = div_u64((term * r) >> 31, 64'(n));
            sum  = sum + term;
        end
        e = div_u64((64'd1 << 62) + (sum >> 1), sum);
        for (int n = 0; n < 5; n++) begin
            e = (e * e + (64'd1 << 30)) >> 31;
        end
        num = ((64'd1 << 31) - e) << 30;
        den = (64'd1 << 31) + e;
        return TANH_W'(div_u64(num + (den >> 1), den));
    endfunction

    logic [TANH_W-1:0] w_tab [TANH_TABLE_ENTRIES+1];

    for (genvar g = 0; g <= TANH_TABLE_ENTRIES; g++) begin : g_tab
        localparam logic [TANH_W-1:0] ENTRY = tanh_entry(g);
        assign w_tab[g] = ENTRY;
    end

    logic en_e, en_f, en_g;

    logic                            r_e_v, r_f_v, r_g_v;
    logic signed [SAMPLE_BITS-1:0]   r_e_x, r_f_x, r_g_x;
    logic                            r_e_sign, r_f_sign, r_g_sign;
    logic                            r_e_sat, r_f_sat;
    logic        [IW-1:0]            r_e_idx;
    logic        [ARG_LIMIT_SHIFT-1:0] r_e_fr, r_f_fr;
    logic        [TANH_W-1:0]        r_f_lo, r_f_diff, r_g_ym;

    logic        [POS_W-1:0]         w_pos;
    logic                            n_e_sat;
    logic        [IW-1:0]            w_idx_hi;
    logic        [TANH_W-1:0]        w_lo, w_hi, n_f_diff, n_g_ym;
    logic        [PG_W-1:0]          w_prod_g, w_rnd_g;

    assign en_g    = !r_g_v || i_ready;
    assign en_f    = !r_f_v || en_g;
    assign en_e    = !r_e_v || en_f;
    assign o_ready = en_e;

    // Table position: |z| * N / 8, integer part indexes, fraction in Q.27
    assign n_e_sat = |i_z[Z3_W-1:ARG_LIMIT_SHIFT];
    assign w_pos   = {{IW{1'b0}}, i_z[ARG_LIMIT_SHIFT-1:0]} * POS_W'(TANH_TABLE_ENTRIES);

    // Neighboring entries; the slope never goes negative
    assign w_idx_hi = r_e_idx + IW'(1);
    assign w_lo     = w_tab[r_e_idx];
    assign w_hi     = w_tab[w_idx_hi];
    assign n_f_diff = (w_hi < w_lo) ? '0 : (w_hi - w_lo);

    // Interpolation, rounded half up
    assign w_prod_g = {{ARG_LIMIT_SHIFT{1'b0}}, r_f_diff} * {{TANH_W{1'b0}}, r_f_fr};
    assign w_rnd_g  = w_prod_g + (PG_W'(1) << (ARG_LIMIT_SHIFT - 1));
    assign n_g_ym   = r_f_sat ? TANH_ONE : (r_f_lo + w_rnd_g[ARG_LIMIT_SHIFT +: TANH_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else begin
            if (en_e) r_e_v <= i_valid;
            if (en_f) r_f_v <= r_e_v;
            if (en_g) r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_e_x    <= i_x;
            r_e_sign <= i_sign;
            r_e_sat  <= n_e_sat;
            r_e_idx  <= w_pos[ARG_LIMIT_SHIFT +: IW];
            r_e_fr   <= w_pos[ARG_LIMIT_SHIFT-1:0];
        end
        if (en_f) begin
            r_f_x    <= r_e_x;
            r_f_sign <= r_e_sign;
            r_f_sat  <= r_e_sat;
            r_f_fr   <= r_e_fr;
            r_f_lo   <= w_lo;
            r_f_diff <= n_f_diff;
        end
        if (en_g) begin
            r_g_x    <= r_f_x;
            r_g_sign <= r_f_sign;
            r_g_ym   <= n_g_ym;
        end
    end

    assign o_valid = r_g_v;
    assign o_x     = r_g_x;
    assign o_ym    = r_g_ym;
    assign o_sign  = r_g_sign;

    // Large arguments clip to exactly one
    a_sat_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_v && r_f_sat && en_g) |=> (r_g_ym == TANH_ONE))
        else $error("saturated argument did not give unit tanh");

    // Interpolation never overshoots full scale
    a_ym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_v && en_g) |=> (r_g_ym <= TANH_ONE))
        else $error("tanh magnitude above one");

endmodule

FILE: hw/rtl/tsw_mix.sv
// ============================================================================
// tsw_mix: dry/wet mix and makeup gain
// Four stages: wet difference, wet product and sum, makeup product,
// rounding and saturation into the output register.
// ============================================================================
module tsw_mix import tsw_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cfg                          i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic        [TANH_W-1:0]      i_ym,
    input  logic                          i_sign,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    localparam int OSH = 47 - SAMPLE_BITS;     // Q.31 * Q1.15 back to sample
    localparam logic signed [PJ_W-1:0] O_MAX = (PJ_W'(1) << (SAMPLE_BITS - 1)) - PJ_W'(1);
    localparam logic signed [PJ_W-1:0] O_MIN = -O_MAX - PJ_W'(1);
    localparam logic signed [PJ_W-1:0] O_HALF = PJ_W'(1) << (OSH - 1);
    localparam logic signed [PI_W-1:0] W_HALF = PI_W'(1) << (WET_FRAC - 1);

    logic en_h, en_i, en_j, en_k;

    logic                          r_h_v, r_i_v, r_j_v, r_k_v;
    logic signed [DIFF_W-1:0]      r_h_d;
    logic signed [X31_W-1:0]       r_h_x31;
    logic signed [MIX_W-1:0]       r_i_mix;
    logic signed [PJ_W-1:0]        r_j_prod;
    logic signed [SAMPLE_BITS-1:0] r_k_out;

    logic signed [DIFF_W-1:0]      w_y, w_y2, w_x31e, n_h_d;
    logic signed [X31_W-1:0]       w_x31;
    logic signed [PI_W-1:0]        w_prod_i, w_t, w_sum_i;
    logic signed [PJ_W-1:0]        w_prod_j, w_rnd_k;
    logic signed [SAMPLE_BITS-1:0] n_k_out;

    assign en_k    = !r_k_v || i_ready;
    assign en_j    = !r_j_v || en_k;
    assign en_i    = !r_i_v || en_j;
    assign en_h    = !r_h_v || en_i;
    assign o_ready = en_h;

    // Signed tanh in Q.31 minus the dry sample in Q.31
    assign w_y    = i_sign ? -$signed(DIFF_W'(i_ym)) : $signed(DIFF_W'(i_ym));
    assign w_y2   = w_y <<< 1;
    assign w_x31  = X31_W'(i_x) <<< (X31_W - SAMPLE_BITS);
    assign w_x31e = DIFF_W'(w_x31);
    assign n_h_d  = w_y2 - w_x31e;

    // Wet blend: x + round((y - x) * wet)
    assign w_prod_i = PI_W'(r_h_d) * $signed({{(PI_W-GAIN_W){1'b0}}, i_cfg.wet_mix});
    assign w_t      = (w_prod_i + W_HALF) >>> WET_FRAC;
    assign w_sum_i  = PI_W'(r_h_x31) + w_t;

    // Makeup gain
    assign w_prod_j = PJ_W'(r_i_mix) * $signed({{(PJ_W-GAIN_W){1'b0}}, i_cfg.makeup_gain});

    // Round half up and clamp to full scale
    assign w_rnd_k = (r_j_prod + O_HALF) >>> OSH;
    always_comb begin
        if (w_rnd_k > O_MAX) begin
            n_k_out = O_MAX[SAMPLE_BITS-1:0];
        end else if (w_rnd_k < O_MIN) begin
            n_k_out = O_MIN[SAMPLE_BITS-1:0];
        end else begin
            n_k_out = w_rnd_k[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
            r_i_v <= 1'b0;
            r_j_v <= 1'b0;
            r_k_v <= 1'b0;
        end else begin
            if (en_h) r_h_v <= i_valid;
            if (en_i) r_i_v <= r_h_v;
            if (en_j) r_j_v <= r_i_v;
            if (en_k) r_k_v <= r_j_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_h) begin
            r_h_d   <= n_h_d;
            r_h_x31 <= w_x31;
        end
        if (en_i) begin
            r_i_mix <= w_sum_i[MIX_W-1:0];
        end
        if (en_j) begin
            r_j_prod <= w_prod_j;
        end
        if (en_k) begin
            r_k_out <= n_k_out;
        end
    end

    assign o_valid  = r_k_v;
    assign o_sample = r_k_out;

    // Rounding never lifts a negative product above zero
    a_neg_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_j_v && en_k && r_j_prod[PJ_W-1]) |=> (r_k_out[SAMPLE_BITS-1] || r_k_out == '0))
        else $error("negative mix produced positive output");

endmodule

FILE: hw/rtl/tanh_waveshaper_distortion.sv
// ============================================================================
// tanh_waveshaper_distortion: tanh soft-clip waveshaper
//
//   channel   dir  handshake         payload
//   i_smp     in   valid/ready       sample_in  (signed Q0.SAMPLE_BITS-1)
//   o_smp     out  valid/ready       sample_out (signed, saturated)
//   i_cfg_*   in   write enable only register index, 16-bit data
//
// One request per cycle sustained while the output is ready; pipeline of
// 4 argument stages, 3 table stages and 4 mix stages.
// Reset clears all valid bits and loads unity gains, k = 1, full wet.
// A blocked output stalls only the stages behind it that are full; empty
// stages keep filling, so input stays ready while bubbles remain.
// ============================================================================
module tanh_waveshaper_distortion import tsw_pkg::*; #(
    parameter int SAMPLE_BITS        = SAMPLE_BITS_DEF,
    parameter int TANH_TABLE_ENTRIES = TANH_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    tsw_in_if.sink                i_smp,
    tsw_out_if.source             o_smp
);

    t_cfg r_cfg;

    logic                          w_arg_v, w_arg_rdy, w_arg_sign;
    logic signed [SAMPLE_BITS-1:0] w_arg_x;
    logic        [Z3_W-1:0]        w_arg_z;
    logic                          w_tanh_v, w_tanh_rdy, w_tanh_sign;
    logic signed [SAMPLE_BITS-1:0] w_tanh_x;
    logic        [TANH_W-1:0]      w_tanh_ym;
    logic                          w_mix_rdy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_gain         <= DRIVE_RST;
            r_cfg.makeup_gain        <= MAKEUP_RST;
            r_cfg.wet_mix            <= WET_RST;
            r_cfg.shape_amount       <= SHAPE_RST;
            r_cfg.negative_asymmetry <= ASYM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DRIVE:  r_cfg.drive_gain         <= i_cfg_wdata[DRIVE_W-1:0];
                CFG_MAKEUP: r_cfg.makeup_gain        <= i_cfg_wdata;
                CFG_WET:    r_cfg.wet_mix            <= i_cfg_wdata;
                CFG_SHAPE:  r_cfg.shape_amount       <= i_cfg_wdata;
                CFG_ASYM:   r_cfg.negative_asymmetry <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Argument: drive, asymmetry, shape
    tsw_arg #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_arg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_smp.valid),
        .o_ready  (i_smp.ready),
        .i_sample (i_smp.sample_in),
        .o_valid  (w_arg_v),
        .i_ready  (w_arg_rdy),
        .o_x      (w_arg_x),
        .o_z      (w_arg_z),
        .o_sign   (w_arg_sign)
    );

    // Table tanh
    tsw_tanh #(
        .SAMPLE_BITS        (SAMPLE_BITS),
        .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
    ) u_tanh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_arg_v),
        .o_ready (w_arg_rdy),
        .i_x     (w_arg_x),
        .i_z     (w_arg_z),
        .i_sign  (w_arg_sign),
        .o_valid (w_tanh_v),
        .i_ready (w_tanh_rdy),
        .o_x     (w_tanh_x),
        .o_ym    (w_tanh_ym),
        .o_sign  (w_tanh_sign)
    );

    // Mix and makeup
    tsw_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_tanh_v),
        .o_ready  (w_tanh_rdy),
        .i_x      (w_tanh_x),
        .i_ym     (w_tanh_ym),
        .i_sign   (w_tanh_sign),
        .o_valid  (o_smp.valid),
        .i_ready  (w_mix_rdy),
        .o_sample (o_smp.sample_out)
    );

    assign w_mix_rdy = o_smp.ready;

endmodule
